[sv/xeau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package xeau_pkg;

  // kind of an input beat, carried in s_axis_tuser
  localparam logic OP_WRITE_REG = 1'b0;
  localparam logic OP_COMPUTE   = 1'b1;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 72;

  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP_W  = 2'd2;
  localparam logic [1:0] MOD_REG     = 2'd3;

  localparam logic [2:0] REG_EBX = 3'd3;
  localparam logic [2:0] REG_ESP = 3'd4;
  localparam logic [2:0] REG_EBP = 3'd5;
  localparam logic [2:0] REG_ESI = 3'd6;
  localparam logic [2:0] REG_EDI = 3'd7;

  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_DISP32  = 3'd5;
  localparam logic [2:0] RM16_DIRECT = 3'd6;
  localparam logic [2:0] SIB_NO_INDEX = 3'd4;

  // 16-bit rm forms
  localparam logic [2:0] RM16_BX_SI = 3'd0;
  localparam logic [2:0] RM16_BX_DI = 3'd1;
  localparam logic [2:0] RM16_BP_SI = 3'd2;
  localparam logic [2:0] RM16_BP_DI = 3'd3;
  localparam logic [2:0] RM16_SI    = 3'd4;
  localparam logic [2:0] RM16_DI    = 3'd5;
  localparam logic [2:0] RM16_BP    = 3'd6;

  localparam logic [15:0] WRAP16_MASK = 16'hFFFF;

  // decoded compute beat held in the input register
  typedef struct packed {
    logic        addr32;
    logic [7:0]  modrm;
    logic [39:0] trailing_bytes;
    logic [31:0] seg_base;
    logic [31:0] ss_base;
    logic        seg_override;
  } ea_req_t;

  // offset stage result, linear add still to do
  typedef struct packed {
    logic        is_memory;
    logic [31:0] offset;
    logic [31:0] base_sel;
    logic        uses_ss;
    logic [2:0]  bytes_consumed;
  } ea_off_t;

endpackage
`default_nettype wire

[sv/x86_effective_address_unit_core.sv]
// x86 effective address unit: ModRM / SIB address generation.
// slave stream: one beat per item; tuser = opcode. a write beat (opcode 0)
// loads reg_value into the local register copy selected by reg_index and
// gives no result. a compute beat (opcode 1) gives exactly one master beat.
// master stream: is_memory, offset, linear_address, uses_ss, bytes_consumed.
// path: a compute beat passes through the input register, the offset stage
// and the linear address stage before it is shown on m_axis_tvalid.
// throughput: one beat per cycle on either side unless stalled; the register read
// and the three-term offset add sit in one stage, the segment base add in the next.
// a register write takes effect at the edge it is accepted, so every compute
// beat accepted after it sees the new value, earlier ones see the old one.
// stall: while m_axis_tready is low, a full stage holds behind a held stage;
// bubbles are squeezed out, and s_axis_tready drops only when every stage is full.
// reset (rst, synchronous): pipeline emptied and all eight registers cleared.
`timescale 1ns / 1ps
`default_nettype none
module x86_effective_address_unit_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // reg_index[2:0] reg_value[34:3] addr32[35] modrm[43:36]
  // trailing_bytes[83:44] seg_base[115:84] ss_base[147:116]
  // seg_override[148] zero[151:149]
  input  wire logic [xeau_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // is_memory[0] offset[32:1] linear_address[64:33] uses_ss[65]
  // bytes_consumed[68:66] zero[71:69]
  output logic [xeau_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import xeau_pkg::*;

  logic [31:0] regs [8];

  logic    v1, v2, v3;
  logic    en1, en2, en3;
  ea_req_t req;
  ea_off_t stg2;
  ea_off_t stg2_next;
  ea_off_t res;
  logic [31:0] linear_address;

  logic       s_accept;
  logic [2:0] in_reg_index;
  logic [31:0] in_reg_value;
  ea_req_t    in_req;

  assign in_reg_index        = s_axis_tdata[2:0];
  assign in_reg_value        = s_axis_tdata[34:3];
  assign in_req.addr32       = s_axis_tdata[35];
  assign in_req.modrm        = s_axis_tdata[43:36];
  assign in_req.trailing_bytes = s_axis_tdata[83:44];
  assign in_req.seg_base     = s_axis_tdata[115:84];
  assign in_req.ss_base      = s_axis_tdata[147:116];
  assign in_req.seg_override = s_axis_tdata[148];

  assign en3 = !v3 || m_axis_tready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // register copy, written as the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) regs[i] <= '0;
    end else if (s_accept && s_axis_tuser == OP_WRITE_REG) begin
      regs[in_reg_index] <= in_reg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= s_accept && s_axis_tuser == OP_COMPUTE;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) req <= in_req;
    if (en2) stg2 <= stg2_next;
    if (en3) begin
      res            <= stg2;
      linear_address <= stg2.base_sel + stg2.offset;
    end
  end

  // offset decode
  logic [1:0]  mod;
  logic [2:0]  rm;
  logic [39:0] t;
  logic        ovr;
  logic [2:0]  sib_base, sib_index;
  logic [1:0]  sib_scale;
  logic [31:0] d8_lo, d8_hi, d32_lo, d32_hi;
  logic [31:0] base_term, index_term, disp_term;
  logic [15:0] a16, pair_a, pair_b, disp16;
  logic        ss;
  logic [2:0]  used;
  logic [31:0] off;

  always_comb begin
    mod       = req.modrm[7:6];
    rm        = req.modrm[2:0];
    t         = req.trailing_bytes;
    ovr       = req.seg_override;
    sib_base  = t[2:0];
    sib_index = t[5:3];
    sib_scale = t[7:6];
    d8_lo     = {{24{t[7]}}, t[7:0]};
    d8_hi     = {{24{t[15]}}, t[15:8]};
    d32_lo    = t[31:0];
    d32_hi    = t[39:8];
    base_term  = '0;
    index_term = '0;
    disp_term  = '0;
    pair_a     = '0;
    pair_b     = '0;
    disp16     = '0;
    a16        = '0;
    ss         = 1'b0;
    used       = '0;
    off        = '0;

    if (req.addr32) begin
      if (rm == RM_SIB) begin
        if (mod == MOD_NO_DISP && sib_base == RM_DISP32) begin
          disp_term = d32_hi;
          used      = 3'd5;
        end else begin
          base_term = regs[sib_base];
          if (mod == MOD_DISP8) begin
            disp_term = d8_hi;
            used      = 3'd2;
          end else if (mod == MOD_DISP_W) begin
            disp_term = d32_hi;
            used      = 3'd5;
          end else begin
            used = 3'd1;
          end
          ss = (sib_base == REG_ESP || sib_base == REG_EBP) && !ovr;
        end
        if (sib_index != SIB_NO_INDEX)
          index_term = regs[sib_index] << sib_scale;
      end else if (mod == MOD_NO_DISP) begin
        if (rm == RM_DISP32) begin
          disp_term = d32_lo;
          used      = 3'd4;
        end else begin
          base_term = regs[rm];
        end
      end else begin
        base_term = regs[rm];
        ss        = (rm == REG_EBP) && !ovr;
        if (mod == MOD_DISP8) begin
          disp_term = d8_lo;
          used      = 3'd1;
        end else begin
          disp_term = d32_lo;
          used      = 3'd4;
        end
      end
      off = base_term + index_term + disp_term;
    end else begin
      if (mod == MOD_NO_DISP && rm == RM16_DIRECT) begin
        disp16 = t[15:0];
        used   = 3'd2;
      end else begin
        case (mod)
          MOD_DISP8: begin
            disp16 = d8_lo[15:0];
            used   = 3'd1;
          end
          MOD_DISP_W: begin
            disp16 = t[15:0];
            used   = 3'd2;
          end
          default: begin
            disp16 = '0;
            used   = 3'd0;
          end
        endcase
        case (rm)
          RM16_BX_SI: begin pair_a = regs[REG_EBX][15:0]; pair_b = regs[REG_ESI][15:0]; end
          RM16_BX_DI: begin pair_a = regs[REG_EBX][15:0]; pair_b = regs[REG_EDI][15:0]; end
          RM16_BP_SI: begin pair_a = regs[REG_EBP][15:0]; pair_b = regs[REG_ESI][15:0]; end
          RM16_BP_DI: begin pair_a = regs[REG_EBP][15:0]; pair_b = regs[REG_EDI][15:0]; end
          RM16_SI: pair_a = regs[REG_ESI][15:0];
          RM16_DI: pair_a = regs[REG_EDI][15:0];
          RM16_BP: pair_a = regs[REG_EBP][15:0];
          default: pair_a = regs[REG_EBX][15:0];
        endcase
        ss = (rm == RM16_BP_SI || rm == RM16_BP_DI || rm == RM16_BP) && !ovr;
      end
      a16 = (pair_a + pair_b + disp16) & WRAP16_MASK;
      off = {16'h0000, a16};
    end

    if (mod == MOD_REG) begin
      stg2_next.is_memory      = 1'b0;
      stg2_next.offset         = '0;
      stg2_next.base_sel       = '0;
      stg2_next.uses_ss        = 1'b0;
      stg2_next.bytes_consumed = '0;
    end else begin
      stg2_next.is_memory      = 1'b1;
      stg2_next.offset         = off;
      stg2_next.base_sel       = ss ? req.ss_base : req.seg_base;
      stg2_next.uses_ss        = ss;
      stg2_next.bytes_consumed = used;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {3'b000, res.bytes_consumed, res.uses_ss, linear_address,
                          res.offset, res.is_memory};

endmodule
`default_nettype wire
